### rtl/qtmc_pkg.sv
package qtmc_pkg;

   // field widths
   localparam int QUAT_W  = 16;
   localparam int SCALE_W = 16;
   localparam int FIX_W   = 32;

   // raw product of two quaternion parts, and a doubled sum of two of them
   localparam int PROD_W = 2 * QUAT_W;
   localparam int SUM_W  = PROD_W + 2;

   // sum times scale, before rounding
   localparam int WIDE_W = SUM_W + SCALE_W;

   // fraction bits: sums are Q.28, scaled products Q.36, results Q16.16
   localparam int FRAC_SUM  = 2 * (QUAT_W - 2);
   localparam int FRAC_WIDE = FRAC_SUM + 8;
   localparam int FRAC_FIX  = 16;
   localparam int DROP_W    = FRAC_WIDE - FRAC_FIX;
   localparam int RND_W     = WIDE_W - DROP_W;

   // pipeline depth from accept to result beat
   localparam int LATENCY = 5;

   typedef logic signed [QUAT_W-1:0]  quat_type;
   typedef logic signed [SCALE_W-1:0] scale_type;
   typedef logic signed [FIX_W-1:0]   fix_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   // the constant one at Q.28
   localparam sum_type ONE_SUM = sum_type'(64'd1 << FRAC_SUM);

endpackage

### rtl/quaternion_trs_matrix_compose_unit.sv
// Quaternion, axis scale and position to a column-major 4x4 transform.
// A request beat is taken at each rising edge where start is high and busy
// is low. busy is low whenever reset is low, so a new beat may be issued in
// every cycle; the block runs at one item per clock.
// Each request gives one response beat: rsp_valid is high for exactly one
// cycle with the nine scaled rotation entries (rsp_c0r0 .. rsp_c2r2) and
// the translation column (rsp_trans_x/y/z). The bottom row 0,0,0,1 is
// implied. Results are Q16.16, rounded half up and saturated.
// The response beat leaves the pipeline after these registered stages:
// input register, nine 16x16 products, doubled sums and differences,
// scale multiply, then round and clamp.
// The receiver cannot hold off a response; results come out in request
// order and nothing is buffered beyond the pipeline.
// A synchronous reset clears all valid bits so no response beat follows
// reset; busy is high while reset is held.
module quaternion_trs_matrix_compose_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  qtmc_pkg::quat_type  req_quat_x,
   input  qtmc_pkg::quat_type  req_quat_y,
   input  qtmc_pkg::quat_type  req_quat_z,
   input  qtmc_pkg::quat_type  req_quat_w,
   input  qtmc_pkg::scale_type req_scale_x,
   input  qtmc_pkg::scale_type req_scale_y,
   input  qtmc_pkg::scale_type req_scale_z,
   input  qtmc_pkg::fix_type   req_pos_x,
   input  qtmc_pkg::fix_type   req_pos_y,
   input  qtmc_pkg::fix_type   req_pos_z,
   output logic                rsp_valid,
   output qtmc_pkg::fix_type   rsp_c0r0,
   output qtmc_pkg::fix_type   rsp_c0r1,
   output qtmc_pkg::fix_type   rsp_c0r2,
   output qtmc_pkg::fix_type   rsp_c1r0,
   output qtmc_pkg::fix_type   rsp_c1r1,
   output qtmc_pkg::fix_type   rsp_c1r2,
   output qtmc_pkg::fix_type   rsp_c2r0,
   output qtmc_pkg::fix_type   rsp_c2r1,
   output qtmc_pkg::fix_type   rsp_c2r2,
   output qtmc_pkg::fix_type   rsp_trans_x,
   output qtmc_pkg::fix_type   rsp_trans_y,
   output qtmc_pkg::fix_type   rsp_trans_z
);
   import qtmc_pkg::*;

   typedef struct packed {
      scale_type x;
      scale_type y;
      scale_type z;
   } scale3_type;

   typedef struct packed {
      fix_type x;
      fix_type y;
      fix_type z;
   } pos3_type;

   function automatic sum_type dbl(input prod_type p);
      dbl = sum_type'(p) <<< 1;
   endfunction

   logic                accept;
   logic [LATENCY-1:0]  valid_ff;
   logic [LATENCY-1:0]  valid_in;

   // stage 1: input register
   quat_type    qx_ff, qy_ff, qz_ff, qw_ff;
   scale3_type  scale_s1_ff;
   pos3_type    pos_ff [LATENCY];

   // stage 2: raw products
   prod_type    p_xx_ff, p_xy_ff, p_xz_ff, p_yy_ff, p_yz_ff;
   prod_type    p_zz_ff, p_wx_ff, p_wy_ff, p_wz_ff;
   scale3_type  scale_s2_ff;

   // stage 3: rotation entries before scaling
   sum_type     m00_ff, m01_ff, m02_ff, m10_ff, m11_ff, m12_ff;
   sum_type     m20_ff, m21_ff, m22_ff;
   scale3_type  scale_s3_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // valid bits travel with the data
   always_comb begin
      valid_in = {valid_ff[LATENCY-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      qx_ff         <= req_quat_x;
      qy_ff         <= req_quat_y;
      qz_ff         <= req_quat_z;
      qw_ff         <= req_quat_w;
      scale_s1_ff   <= '{x: req_scale_x, y: req_scale_y, z: req_scale_z};

      p_xx_ff       <= prod_type'(qx_ff) * prod_type'(qx_ff);
      p_xy_ff       <= prod_type'(qx_ff) * prod_type'(qy_ff);
      p_xz_ff       <= prod_type'(qx_ff) * prod_type'(qz_ff);
      p_yy_ff       <= prod_type'(qy_ff) * prod_type'(qy_ff);
      p_yz_ff       <= prod_type'(qy_ff) * prod_type'(qz_ff);
      p_zz_ff       <= prod_type'(qz_ff) * prod_type'(qz_ff);
      p_wx_ff       <= prod_type'(qw_ff) * prod_type'(qx_ff);
      p_wy_ff       <= prod_type'(qw_ff) * prod_type'(qy_ff);
      p_wz_ff       <= prod_type'(qw_ff) * prod_type'(qz_ff);
      scale_s2_ff   <= scale_s1_ff;

      m00_ff        <= ONE_SUM - (dbl(p_yy_ff) + dbl(p_zz_ff));
      m01_ff        <= dbl(p_xy_ff) + dbl(p_wz_ff);
      m02_ff        <= dbl(p_xz_ff) - dbl(p_wy_ff);
      m10_ff        <= dbl(p_xy_ff) - dbl(p_wz_ff);
      m11_ff        <= ONE_SUM - (dbl(p_xx_ff) + dbl(p_zz_ff));
      m12_ff        <= dbl(p_yz_ff) + dbl(p_wx_ff);
      m20_ff        <= dbl(p_xz_ff) + dbl(p_wy_ff);
      m21_ff        <= dbl(p_yz_ff) - dbl(p_wx_ff);
      m22_ff        <= ONE_SUM - (dbl(p_xx_ff) + dbl(p_yy_ff));
      scale_s3_ff   <= scale_s2_ff;
   end

   // translation delay line
   always_ff @(posedge clock) begin
      pos_ff[0] <= '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
      for (int i = 1; i < LATENCY; i++) begin
         pos_ff[i] <= pos_ff[i-1];
      end
   end

   // stages 4 and 5: scale, round and clamp each entry
   qtmc_scale_round u_c0r0 (.clock, .sum_in(m00_ff), .scale_in(scale_s3_ff.x), .result(rsp_c0r0));
   qtmc_scale_round u_c0r1 (.clock, .sum_in(m01_ff), .scale_in(scale_s3_ff.x), .result(rsp_c0r1));
   qtmc_scale_round u_c0r2 (.clock, .sum_in(m02_ff), .scale_in(scale_s3_ff.x), .result(rsp_c0r2));
   qtmc_scale_round u_c1r0 (.clock, .sum_in(m10_ff), .scale_in(scale_s3_ff.y), .result(rsp_c1r0));
   qtmc_scale_round u_c1r1 (.clock, .sum_in(m11_ff), .scale_in(scale_s3_ff.y), .result(rsp_c1r1));
   qtmc_scale_round u_c1r2 (.clock, .sum_in(m12_ff), .scale_in(scale_s3_ff.y), .result(rsp_c1r2));
   qtmc_scale_round u_c2r0 (.clock, .sum_in(m20_ff), .scale_in(scale_s3_ff.z), .result(rsp_c2r0));
   qtmc_scale_round u_c2r1 (.clock, .sum_in(m21_ff), .scale_in(scale_s3_ff.z), .result(rsp_c2r1));
   qtmc_scale_round u_c2r2 (.clock, .sum_in(m22_ff), .scale_in(scale_s3_ff.z), .result(rsp_c2r2));

   // response beat
   assign rsp_valid   = valid_ff[LATENCY-1];
   assign rsp_trans_x = pos_ff[LATENCY-1].x;
   assign rsp_trans_y = pos_ff[LATENCY-1].y;
   assign rsp_trans_z = pos_ff[LATENCY-1].z;

endmodule

### rtl/qtmc_scale_round.sv
module qtmc_scale_round (
   input  logic              clock,
   input  qtmc_pkg::sum_type   sum_in,
   input  qtmc_pkg::scale_type scale_in,
   output qtmc_pkg::fix_type   result
);
   import qtmc_pkg::*;

   localparam int CMP_W = FIX_W + 2;
   localparam logic signed [CMP_W-1:0] FIX_MAX = CMP_W'((64'd1 << (FIX_W - 1)) - 64'd1);
   localparam logic signed [CMP_W-1:0] FIX_MIN = -(CMP_W'(64'd1 << (FIX_W - 1)));
   localparam wide_type HALF_LSB = wide_type'(64'd1 << (DROP_W - 1));

   wide_type                 wide_ff;
   wide_type                 wide_in;
   wide_type                 rounded;
   logic signed [RND_W-1:0]  shifted;
   logic signed [CMP_W-1:0]  ext;
   fix_type                  result_ff;
   fix_type                  result_in;

   // scale multiply
   always_comb begin
      wide_in = wide_type'(sum_in) * wide_type'(scale_in);
   end

   // round half up, drop fraction bits, clamp to 32 bits
   always_comb begin
      rounded = wide_ff + HALF_LSB;
      shifted = RND_W'(rounded >>> DROP_W);
      ext     = CMP_W'(shifted);
      if (ext > FIX_MAX) begin
         result_in = fix_type'(FIX_MAX);
      end else if (ext < FIX_MIN) begin
         result_in = fix_type'(FIX_MIN);
      end else begin
         result_in = fix_type'(ext);
      end
   end

   always_ff @(posedge clock) begin
      wide_ff   <= wide_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

### rtl/qtmc_checker.sv
module qtmc_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input qtmc_pkg::scale_type req_scale_x,
   input qtmc_pkg::fix_type   req_pos_x,
   input logic                rsp_valid,
   input qtmc_pkg::fix_type   rsp_c0r0,
   input qtmc_pkg::fix_type   rsp_c0r1,
   input qtmc_pkg::fix_type   rsp_c0r2,
   input qtmc_pkg::fix_type   rsp_trans_x
);
   import qtmc_pkg::*;

   // every accepted beat comes back as a response beat
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##5 rsp_valid)
      else $error("accepted beat gave no response");

   // no response without a matching request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("response beat without a request");

   // translation passes through unchanged
   a_trans_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_trans_x == $past(req_pos_x, 5))
      else $error("translation x corrupted");

   // a zero x scale zeroes the whole first column
   a_zero_scale: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_scale_x == '0 |-> ##5
         (rsp_c0r0 == '0 && rsp_c0r1 == '0 && rsp_c0r2 == '0))
      else $error("zero scale gave nonzero column");

endmodule

bind quaternion_trs_matrix_compose_unit qtmc_checker u_qtmc_checker (.*);

### tb/sv/qtmc_tb_pkg.sv
`timescale 1ns / 1ps

package qtmc_tb_pkg;

   import qtmc_pkg::*;

   // one request beat: quaternion, axis scales, position
   typedef struct packed {
      quat_type  qx;
      quat_type  qy;
      quat_type  qz;
      quat_type  qw;
      scale_type sx;
      scale_type sy;
      scale_type sz;
      fix_type   px;
      fix_type   py;
      fix_type   pz;
   } pose_type;

   // one response beat: scaled rotation columns and translation
   typedef struct packed {
      fix_type c0r0;
      fix_type c0r1;
      fix_type c0r2;
      fix_type c1r0;
      fix_type c1r1;
      fix_type c1r2;
      fix_type c2r0;
      fix_type c2r1;
      fix_type c2r2;
      fix_type trans_x;
      fix_type trans_y;
      fix_type trans_z;
   } xform_type;

   localparam int     REPORT_MAX = 10;
   localparam longint FIX_MAX    = (longint'(1) <<< 31) - 1;
   localparam longint FIX_MIN    = -(longint'(1) <<< 31);
   localparam longint ONE_Q28    = longint'(1) <<< 28;
   localparam longint HALF_LSB   = longint'(1) <<< 19;

   class xform_scoreboard;

      xform_type   expected_xforms[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Q.28 sum times Q8.8 scale, round half up to Q16.16, clamp
      static function fix_type scale_round(longint q28, scale_type s);
         longint p;
         longint r;
         p = q28 * longint'(s) + HALF_LSB;
         r = p >>> 20;
         if (r > FIX_MAX) begin
            r = FIX_MAX;
         end else if (r < FIX_MIN) begin
            r = FIX_MIN;
         end
         return fix_type'(r);
      endfunction

      // rotation matrix from doubled products, columns scaled per axis
      static function xform_type compose_transform(pose_type p);
         longint x, y, z, w;
         longint xx, xy, xz, yy, yz, zz, wx, wy, wz;
         xform_type m;
         x = p.qx;
         y = p.qy;
         z = p.qz;
         w = p.qw;
         xx = 2 * x * x;
         xy = 2 * x * y;
         xz = 2 * x * z;
         yy = 2 * y * y;
         yz = 2 * y * z;
         zz = 2 * z * z;
         wx = 2 * w * x;
         wy = 2 * w * y;
         wz = 2 * w * z;
         m.c0r0    = scale_round(ONE_Q28 - (yy + zz), p.sx);
         m.c0r1    = scale_round(xy + wz, p.sx);
         m.c0r2    = scale_round(xz - wy, p.sx);
         m.c1r0    = scale_round(xy - wz, p.sy);
         m.c1r1    = scale_round(ONE_Q28 - (xx + zz), p.sy);
         m.c1r2    = scale_round(yz + wx, p.sy);
         m.c2r0    = scale_round(xz + wy, p.sz);
         m.c2r1    = scale_round(yz - wx, p.sz);
         m.c2r2    = scale_round(ONE_Q28 - (xx + yy), p.sz);
         m.trans_x = p.px;
         m.trans_y = p.py;
         m.trans_z = p.pz;
         return m;
      endfunction

      function void note_request(pose_type p);
         expected_xforms.push_back(compose_transform(p));
      endfunction

      function int pending();
         return expected_xforms.size();
      endfunction

      function void compare_entry(string name, fix_type exp_v, fix_type act_v);
         if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("mismatch on %s: expected %h actual %h", name, exp_v, act_v);
            end
         end
      endfunction

      function void check_result(xform_type act);
         xform_type exp_m;
         if (expected_xforms.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("response beat with no request outstanding: %h", act);
            end
            return;
         end
         exp_m = expected_xforms.pop_front();
         compare_entry("c0r0", exp_m.c0r0, act.c0r0);
         compare_entry("c0r1", exp_m.c0r1, act.c0r1);
         compare_entry("c0r2", exp_m.c0r2, act.c0r2);
         compare_entry("c1r0", exp_m.c1r0, act.c1r0);
         compare_entry("c1r1", exp_m.c1r1, act.c1r1);
         compare_entry("c1r2", exp_m.c1r2, act.c1r2);
         compare_entry("c2r0", exp_m.c2r0, act.c2r0);
         compare_entry("c2r1", exp_m.c2r1, act.c2r1);
         compare_entry("c2r2", exp_m.c2r2, act.c2r2);
         compare_entry("trans_x", exp_m.trans_x, act.trans_x);
         compare_entry("trans_y", exp_m.trans_y, act.trans_y);
         compare_entry("trans_z", exp_m.trans_z, act.trans_z);
      endfunction

   endclass

endpackage

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import qtmc_pkg::*;
   import qtmc_tb_pkg::*;

   localparam int RANDOM_ITEMS   = 800;
   localparam int WATCHDOG_LIMIT = 2000;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   quat_type  req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   scale_type req_scale_x, req_scale_y, req_scale_z;
   fix_type   req_pos_x, req_pos_y, req_pos_z;
   logic      rsp_valid;
   fix_type   rsp_c0r0, rsp_c0r1, rsp_c0r2;
   fix_type   rsp_c1r0, rsp_c1r1, rsp_c1r2;
   fix_type   rsp_c2r0, rsp_c2r1, rsp_c2r2;
   fix_type   rsp_trans_x, rsp_trans_y, rsp_trans_z;

   xform_scoreboard sb;
   int              idle_cycles;

   quaternion_trs_matrix_compose_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_quat_x  (req_quat_x),
      .req_quat_y  (req_quat_y),
      .req_quat_z  (req_quat_z),
      .req_quat_w  (req_quat_w),
      .req_scale_x (req_scale_x),
      .req_scale_y (req_scale_y),
      .req_scale_z (req_scale_z),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_pos_z   (req_pos_z),
      .rsp_valid   (rsp_valid),
      .rsp_c0r0    (rsp_c0r0),
      .rsp_c0r1    (rsp_c0r1),
      .rsp_c0r2    (rsp_c0r2),
      .rsp_c1r0    (rsp_c1r0),
      .rsp_c1r1    (rsp_c1r1),
      .rsp_c1r2    (rsp_c1r2),
      .rsp_c2r0    (rsp_c2r0),
      .rsp_c2r1    (rsp_c2r1),
      .rsp_c2r2    (rsp_c2r2),
      .rsp_trans_x (rsp_trans_x),
      .rsp_trans_y (rsp_trans_y),
      .rsp_trans_z (rsp_trans_z)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // accepted beats on both sides, plus the stall watchdog
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else if (!reset) begin
         if (start && !busy) begin
            sb.note_request(pose_type'{req_quat_x, req_quat_y, req_quat_z, req_quat_w,
                                       req_scale_x, req_scale_y, req_scale_z,
                                       req_pos_x, req_pos_y, req_pos_z});
         end
         if (rsp_valid) begin
            sb.check_result(xform_type'{rsp_c0r0, rsp_c0r1, rsp_c0r2,
                                        rsp_c1r0, rsp_c1r1, rsp_c1r2,
                                        rsp_c2r0, rsp_c2r1, rsp_c2r2,
                                        rsp_trans_x, rsp_trans_y, rsp_trans_z});
         end
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic pose_type make_pose(int qx, int qy, int qz, int qw,
                                          int sx, int sy, int sz,
                                          int px, int py, int pz);
      pose_type p;
      p.qx = quat_type'(qx);
      p.qy = quat_type'(qy);
      p.qz = quat_type'(qz);
      p.qw = quat_type'(qw);
      p.sx = scale_type'(sx);
      p.sy = scale_type'(sy);
      p.sz = scale_type'(sz);
      p.px = fix_type'(px);
      p.py = fix_type'(py);
      p.pz = fix_type'(pz);
      return p;
   endfunction

   // 16-bit value leaning toward the extremes now and then
   function automatic logic [15:0] pick_word16();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      case (sel)
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         4: return 16'($urandom_range(0, 32768) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pose_type random_pose();
      pose_type p;
      p.qx = quat_type'(pick_word16());
      p.qy = quat_type'(pick_word16());
      p.qz = quat_type'(pick_word16());
      p.qw = quat_type'(pick_word16());
      p.sx = scale_type'(pick_word16());
      p.sy = scale_type'(pick_word16());
      p.sz = scale_type'(pick_word16());
      p.px = fix_type'($urandom);
      p.py = fix_type'($urandom);
      p.pz = fix_type'($urandom);
      return p;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // present one beat and hold it until taken; start stays up if no gap
   task automatic send_pose(pose_type p, int gap);
      @(negedge clock);
      req_quat_x  = p.qx;
      req_quat_y  = p.qy;
      req_quat_z  = p.qz;
      req_quat_w  = p.qw;
      req_scale_x = p.sx;
      req_scale_y = p.sy;
      req_scale_z = p.sz;
      req_pos_x   = p.px;
      req_pos_y   = p.py;
      req_pos_z   = p.pz;
      start       = 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(posedge clock);
      end
   endtask

   initial begin
      int burst_left;
      pose_type directed_poses[$];

      sb          = new();
      idle_cycles = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_quat_x  = '0;
      req_quat_y  = '0;
      req_quat_z  = '0;
      req_quat_w  = '0;
      req_scale_x = '0;
      req_scale_y = '0;
      req_scale_z = '0;
      req_pos_x   = '0;
      req_pos_y   = '0;
      req_pos_z   = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed: zero, identity, half turns, field extremes, rounding ties
      directed_poses.push_back(make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_poses.push_back(make_pose(0, 0, 0, 16384, 256, 256, 256, 65536, -65536, 1));
      directed_poses.push_back(make_pose(16384, 0, 0, 0, 256, 512, -256, 0, 0, 0));
      directed_poses.push_back(make_pose(0, 16384, 0, 0, -256, 256, 128, 7, 8, 9));
      directed_poses.push_back(make_pose(0, 0, 16384, 0, 256, -512, 256, -7, -8, -9));
      directed_poses.push_back(make_pose(11585, 0, 0, 11585, 256, 256, 256, 0, 0, 0));
      directed_poses.push_back(make_pose(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                         32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      directed_poses.push_back(make_pose(-32768, -32768, -32768, -32768,
                                         -32768, -32768, -32768,
                                         32'h80000000, 32'h80000000, 32'h80000000));
      directed_poses.push_back(make_pose(-32768, 32767, -32768, 32767,
                                         32767, -32768, 32767,
                                         32'h80000000, 32'h7fffffff, 0));
      directed_poses.push_back(make_pose(32767, -32768, 32767, -32768,
                                         -32768, 32767, -32768,
                                         32'h7fffffff, 32'h80000000, -1));
      directed_poses.push_back(make_pose(-32768, -32768, 0, 0, -32768, -32768, -32768,
                                         -1, -1, -1));
      directed_poses.push_back(make_pose(0, -32768, -32768, 0, 32767, 32767, 32767,
                                         32'h55555555, 32'haaaaaaaa, 32'h0000ffff));
      // products landing exactly on a half lsb, both signs
      directed_poses.push_back(make_pose(128, 128, 0, 0, 16, 16, 16, 0, 0, 0));
      directed_poses.push_back(make_pose(128, 128, 0, 0, -16, -16, -16, 0, 0, 0));
      directed_poses.push_back(make_pose(128, -128, 0, 0, 16, -16, 16, 0, 0, 0));
      directed_poses.push_back(make_pose(1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      directed_poses.push_back(make_pose(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      // unnormalized quaternion, no correction expected
      directed_poses.push_back(make_pose(20000, -20000, 20000, 20000, 256, 256, 256,
                                         123456, -654321, 42));
      foreach (directed_poses[i]) begin
         send_pose(directed_poses[i], (i % 3 == 0) ? 0 : 1);
      end

      // random: runs of back to back beats mixed with idle gaps
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0 && $urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 40);
         end
         if (burst_left > 0) begin
            burst_left--;
            send_pose(random_pose(), 0);
         end else begin
            send_pose(random_pose(), pick_gap());
         end
      end

      // drain the pipeline
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * LATENCY + 4) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### quaternion_trs_matrix_compose_unit.f
rtl/qtmc_pkg.sv
rtl/qtmc_scale_round.sv
rtl/quaternion_trs_matrix_compose_unit.sv
rtl/qtmc_checker.sv
tb/sv/qtmc_tb_pkg.sv
tb/sv/testbench.sv
